/* rtl/core/brb_pkg.sv */
// Shared types and constants for the block ring buffer core.
// No dependencies; brb_if, brb_index, the core and the testbench use this package by scoped names.
`timescale 1ns / 1ps

package brb_pkg;

  // Fixed field widths of the channels and registers
  localparam int KIND_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int RLEN_W     = 7;
  localparam int BLOCKS_W   = 5;
  localparam int BYTES_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Register reset values
  localparam logic [BLOCKS_W-1:0] BLOCKS_RST = 5'd16;
  localparam logic [BYTES_W-1:0]  BYTES_RST  = 9'd256;

  // Input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_NODATA = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKS_IN_USE = 1'b0,
    REG_BLOCK_BYTES   = 1'b1
  } cfg_reg_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_DATA
  } state_t;

  // Index updates requested by the control logic
  typedef struct packed {
    logic step;
    logic rd_adv;
    logic wr_adv;
  } idx_upd_t;

  // Ring status flags
  typedef struct packed {
    logic empty;
    logic full;
  } ring_flags_t;

endpackage

/* rtl/core/brb_if.sv */
// Valid/ready channel interfaces for the block ring buffer core.
// Depends on brb_pkg for the payload widths.
`timescale 1ns / 1ps

interface brb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [brb_pkg::BYTE_W-1:0]   data_byte;
  logic                         message_end;
  logic [brb_pkg::RLEN_W-1:0]   read_len;

  modport source (output valid, action, data_byte, message_end, read_len, input ready);
  modport sink   (input valid, action, data_byte, message_end, read_len, output ready);
endinterface

interface brb_out_if;
  logic                         valid;
  logic                         ready;
  logic [brb_pkg::KIND_W-1:0]   kind;
  logic [brb_pkg::BYTE_W-1:0]   out_byte;
  logic [brb_pkg::COUNT_W-1:0]  count;
  logic                         run_last;
  logic                         is_empty;
  logic                         is_full;

  modport source (output valid, kind, out_byte, count, run_last, is_empty, is_full,
                  input ready);
  modport sink   (input valid, kind, out_byte, count, run_last, is_empty, is_full,
                  output ready);
endinterface

/* rtl/core/brb_data_mem.sv */
// Message byte store: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps

module brb_data_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one byte, hold when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/brb_meta_mem.sv */
// Per-block length and read offset store with registered read data.
// Depends on nothing; valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps

module brb_meta_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int DW    = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [DW-1:0]    wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [DW-1:0]    rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rdata_r;
  logic             rvld_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Mark written entries; reset clears all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Registered read with its valid bit
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (re) begin
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

/* rtl/core/brb_index.sv */
// Read and write block indexes, ring flags and index reduction after a
// change of the ring size. Depends on brb_pkg for the update and flag types.
`timescale 1ns / 1ps

module brb_index #(
  parameter int IDX_W = 4,
  parameter int N_W   = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [N_W-1:0]       ring_n,
  input  logic                 reload,
  input  brb_pkg::idx_upd_t    upd,
  output logic [IDX_W-1:0]     rd_idx,
  output logic [IDX_W-1:0]     wr_idx,
  output logic                 busy,
  output brb_pkg::ring_flags_t flags_now,
  output brb_pkg::ring_flags_t flags_nxt
);

  logic [IDX_W-1:0] rd_r, wr_r, rd_save_r, wr_save_r;
  logic [IDX_W-1:0] rd_nxt, wr_nxt;
  logic             rd_over, wr_over;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                input logic [N_W-1:0]   n);
    logic [N_W-1:0] inc;
    inc = N_W'(idx) + N_W'(1);
    return (inc >= n) ? '0 : IDX_W'(inc);
  endfunction

  // Indexes at or beyond the ring size still need reduction
  assign rd_over = (N_W'(rd_r) >= ring_n);
  assign wr_over = (N_W'(wr_r) >= ring_n);
  assign busy    = rd_over || wr_over;

  assign rd_nxt = upd.rd_adv ? step_idx(rd_r, ring_n) : rd_r;
  assign wr_nxt = upd.wr_adv ? step_idx(wr_r, ring_n) : wr_r;

  // Reload from the last stepped values, subtract the ring size, or advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r      <= '0;
      wr_r      <= '0;
      rd_save_r <= '0;
      wr_save_r <= '0;
    end else if (reload) begin
      rd_r <= rd_save_r;
      wr_r <= wr_save_r;
    end else if (busy) begin
      if (rd_over) begin
        rd_r <= IDX_W'(N_W'(rd_r) - ring_n);
      end
      if (wr_over) begin
        wr_r <= IDX_W'(N_W'(wr_r) - ring_n);
      end
    end else if (upd.step) begin
      rd_r      <= rd_nxt;
      wr_r      <= wr_nxt;
      rd_save_r <= rd_nxt;
      wr_save_r <= wr_nxt;
    end
  end

  assign rd_idx = rd_r;
  assign wr_idx = wr_r;

  // Flags now and after the requested update
  assign flags_now.empty = (rd_r == wr_r);
  assign flags_now.full  = (step_idx(wr_r, ring_n) == rd_r);
  assign flags_nxt.empty = (rd_nxt == wr_nxt);
  assign flags_nxt.full  = (step_idx(wr_nxt, ring_n) == rd_nxt);

endmodule

/* rtl/core/block_ring_buffer_core.sv */
// Block ring buffer core: write sequencing, read sequencing, output register.
// Depends on brb_pkg, brb_if, brb_data_mem, brb_meta_mem and brb_index.
//
//   Port     Dir     Handshake    Beat carries
//   in_ch    sink    valid/ready  action, data_byte, message_end, read_len
//   out_ch   source  valid/ready  kind, out_byte, count, run_last, is_empty, is_full
//   cfg_*    in      cfg_we       cfg_index, cfg_wdata (no read-back)
//
// A final write byte loads its status into the output register. A read first fetches
// the block length and offset, then streams one byte per cycle from the byte memory
// (registered read, prefetched one ahead). An empty read loads its status straight into
// the output register. Output stalls hold the stream. After a write of blocks_in_use,
// no input is taken while index reduction runs. Reset is synchronous; no memory
// clearing pass is needed.
`timescale 1ns / 1ps

module block_ring_buffer_core #(
  parameter int MAX_BLOCKS     = 16,
  parameter int BLOCK_CAPACITY = 256,
  parameter int MAX_READ_CHUNK = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  brb_in_if.sink                           in_ch,
  brb_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [brb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int N_W   = $clog2(MAX_BLOCKS + 1);
  localparam int CUR_W = $clog2(BLOCK_CAPACITY + 1);
  localparam int DEPTH = MAX_BLOCKS * BLOCK_CAPACITY;
  localparam int AW    = $clog2(DEPTH);
  localparam int CHK_W = $clog2(MAX_READ_CHUNK + 1);
  localparam int MW    = 2 * CUR_W;

  // Configuration registers
  logic [brb_pkg::BLOCKS_W-1:0] blocks_r;
  logic [brb_pkg::BYTES_W-1:0]  bytes_r;
  logic [N_W-1:0]               ring_n;
  logic [CUR_W-1:0]             cap;
  logic                         reload;

  // Sequencer and datapath registers
  brb_pkg::state_t      state_r, state_nxt;
  logic [CUR_W-1:0]     cursor_r, cursor_nxt;
  logic                 dropping_r, dropping_nxt;
  logic [CHK_W-1:0]     want_r, want_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [CUR_W-1:0]     pos_r, pos_nxt;
  logic [CHK_W-1:0]     size_r, size_nxt;
  logic [CHK_W-1:0]     iss_r, iss_nxt;
  logic [CHK_W-1:0]     emit_r, emit_nxt;
  logic                 pend_r, pend_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  brb_pkg::kind_t               kind_r, kind_nxt;
  logic [brb_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  logic [brb_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         last_r, last_nxt;
  logic                         empty_r, empty_nxt;
  logic                         full_r, full_nxt;

  // Index unit
  logic [IDX_W-1:0]     rd_idx, wr_idx;
  logic                 idx_busy;
  brb_pkg::idx_upd_t    upd;
  brb_pkg::ring_flags_t flags_now, flags_nxt;

  // Memory ports
  logic               dm_we, dm_re;
  logic [AW-1:0]      dm_waddr, dm_raddr;
  logic [7:0]         dm_rdata;
  logic               mm_we, mm_re;
  logic [MW-1:0]      mm_wdata, mm_rdata;

  // Handshake and read sizing
  logic             slot_free, in_ready, acc, load, issue, data_last;
  logic [CUR_W-1:0] m_len, m_off, avail;
  logic [CHK_W-1:0] rd_size;
  logic [CUR_W:0]   off_sum;
  logic             exhausted;
  logic             drop_eff, store, commit;
  logic [CUR_W-1:0] cursor_inc;

  // Clamp register values into their working ranges
  always_comb begin
    if (int'(blocks_r) < 2) begin
      ring_n = N_W'(2);
    end else if (int'(blocks_r) > MAX_BLOCKS) begin
      ring_n = N_W'(MAX_BLOCKS);
    end else begin
      ring_n = N_W'(blocks_r);
    end
    if (int'(bytes_r) < 1) begin
      cap = CUR_W'(1);
    end else if (int'(bytes_r) > BLOCK_CAPACITY) begin
      cap = CUR_W'(BLOCK_CAPACITY);
    end else begin
      cap = CUR_W'(bytes_r);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r <= brb_pkg::BLOCKS_RST;
      bytes_r  <= brb_pkg::BYTES_RST;
    end else if (cfg_we) begin
      unique case (brb_pkg::cfg_reg_t'(cfg_index))
        brb_pkg::REG_BLOCKS_IN_USE: blocks_r <= cfg_wdata[brb_pkg::BLOCKS_W-1:0];
        brb_pkg::REG_BLOCK_BYTES:   bytes_r  <= cfg_wdata[brb_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign reload = cfg_we && (brb_pkg::cfg_reg_t'(cfg_index) == brb_pkg::REG_BLOCKS_IN_USE);

  brb_index #(
    .IDX_W (IDX_W),
    .N_W   (N_W)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .ring_n    (ring_n),
    .reload    (reload),
    .upd       (upd),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .busy      (idx_busy),
    .flags_now (flags_now),
    .flags_nxt (flags_nxt)
  );

  brb_data_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_data_mem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (in_ch.data_byte),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  // Commits write the open block; the read sequencer writes back the oldest block
  brb_meta_mem #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W),
    .DW    (MW)
  ) u_meta_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mm_we),
    .waddr ((state_r == brb_pkg::S_META) ? rd_idx : wr_idx),
    .wdata (mm_wdata),
    .re    (mm_re),
    .raddr (rd_idx),
    .rdata (mm_rdata)
  );

  // Handshake
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == brb_pkg::S_IDLE) && !idx_busy && !cfg_we && slot_free;
  assign acc       = in_ch.valid && in_ready;

  // Write byte decisions
  assign drop_eff   = dropping_r || ((cursor_r == '0) && flags_now.full);
  assign store      = !drop_eff && (cursor_r < cap);
  assign cursor_inc = cursor_r + CUR_W'(store);
  assign commit     = !drop_eff && !flags_now.full;

  // Read sizing from the fetched length and offset
  assign m_len     = mm_rdata[MW-1:CUR_W];
  assign m_off     = mm_rdata[CUR_W-1:0];
  assign avail     = (m_off < m_len) ? (m_len - m_off) : '0;
  assign rd_size   = (int'(avail) < int'(want_r)) ? CHK_W'(avail) : want_r;
  assign off_sum   = (CUR_W+1)'(m_off) + (CUR_W+1)'(rd_size);
  assign exhausted = (off_sum >= (CUR_W+1)'(m_len));

  // Byte stream: prefetch one read ahead of the output register
  assign load      = (state_r == brb_pkg::S_DATA) && pend_r && slot_free;
  assign issue     = (state_r == brb_pkg::S_DATA) && (iss_r != size_r) && (!pend_r || load);
  assign data_last = (CHK_W'(emit_r + CHK_W'(1)) == size_r);
  assign dm_raddr  = base_r + AW'(pos_r);
  assign dm_re     = issue;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brb_pkg::S_IDLE: begin
        if (acc && (in_ch.action == brb_pkg::ACT_READ) && !flags_now.empty) begin
          state_nxt = brb_pkg::S_META;
        end
      end
      brb_pkg::S_META: begin
        state_nxt = (rd_size == '0) ? brb_pkg::S_IDLE : brb_pkg::S_DATA;
      end
      brb_pkg::S_DATA: begin
        if (load && data_last) begin
          state_nxt = brb_pkg::S_IDLE;
        end
      end
      default: state_nxt = brb_pkg::S_IDLE;
    endcase
  end

  // Datapath control and register next values
  always_comb begin
    cursor_nxt    = cursor_r;
    dropping_nxt  = dropping_r;
    want_nxt      = want_r;
    base_nxt      = base_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    iss_nxt       = iss_r;
    emit_nxt      = emit_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    upd           = '0;
    dm_we         = 1'b0;
    dm_waddr      = AW'(int'(wr_idx) * BLOCK_CAPACITY + int'(cursor_r));
    mm_we         = 1'b0;
    mm_re         = 1'b0;
    mm_wdata      = '0;

    unique case (state_r)
      brb_pkg::S_IDLE: begin
        if (acc && (in_ch.action == brb_pkg::ACT_WRITE)) begin
          // Store the byte, commit on the final one
          dm_we = store;
          upd.step = 1'b1;
          if (!in_ch.message_end) begin
            cursor_nxt   = cursor_inc;
            dropping_nxt = drop_eff;
          end else begin
            cursor_nxt   = '0;
            dropping_nxt = 1'b0;
            mm_we        = commit;
            mm_wdata     = {cursor_inc, {CUR_W{1'b0}}};
            upd.wr_adv   = commit;
            out_valid_nxt = 1'b1;
            kind_nxt      = brb_pkg::KIND_WRITE;
            byte_nxt      = '0;
            count_nxt     = commit ? brb_pkg::COUNT_W'(cursor_inc) : '0;
            last_nxt      = 1'b1;
            empty_nxt     = flags_nxt.empty;
            full_nxt      = flags_nxt.full;
          end
        end else if (acc) begin
          // Read request: fetch length and offset, or report empty
          upd.step = 1'b1;
          want_nxt = (int'(in_ch.read_len) > MAX_READ_CHUNK) ?
                     CHK_W'(MAX_READ_CHUNK) : CHK_W'(in_ch.read_len);
          base_nxt = AW'(int'(rd_idx) * BLOCK_CAPACITY);
          if (flags_now.empty) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = brb_pkg::KIND_NODATA;
            byte_nxt      = '0;
            count_nxt     = '0;
            last_nxt      = 1'b1;
            empty_nxt     = flags_nxt.empty;
            full_nxt      = flags_nxt.full;
          end else begin
            mm_re = 1'b1;
          end
        end
      end
      brb_pkg::S_META: begin
        // Write back the offset, drop the block once exhausted
        upd.step   = 1'b1;
        upd.rd_adv = exhausted;
        mm_we      = 1'b1;
        mm_wdata   = {m_len, exhausted ? {CUR_W{1'b0}} : CUR_W'(off_sum)};
        pos_nxt    = m_off;
        size_nxt   = rd_size;
        iss_nxt    = '0;
        emit_nxt   = '0;
        pend_nxt   = 1'b0;
        if (rd_size == '0) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = brb_pkg::KIND_NODATA;
          byte_nxt      = '0;
          count_nxt     = '0;
          last_nxt      = 1'b1;
          empty_nxt     = flags_nxt.empty;
          full_nxt      = flags_nxt.full;
        end
      end
      brb_pkg::S_DATA: begin
        // Advance the byte stream
        if (issue) begin
          pos_nxt = pos_r + CUR_W'(1);
          iss_nxt = iss_r + CHK_W'(1);
        end
        if (issue) begin
          pend_nxt = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load) begin
          emit_nxt      = emit_r + CHK_W'(1);
          out_valid_nxt = 1'b1;
          kind_nxt      = brb_pkg::KIND_DATA;
          byte_nxt      = dm_rdata;
          count_nxt     = brb_pkg::COUNT_W'(emit_r + CHK_W'(1));
          last_nxt      = data_last;
          empty_nxt     = flags_now.empty;
          full_nxt      = flags_now.full;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brb_pkg::S_IDLE;
      cursor_r    <= '0;
      dropping_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      dropping_r  <= dropping_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    want_r  <= want_nxt;
    base_r  <= base_nxt;
    pos_r   <= pos_nxt;
    size_r  <= size_nxt;
    iss_r   <= iss_nxt;
    emit_r  <= emit_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
    full_r  <= full_nxt;
  end

  // Ports
  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.count    = count_r;
  assign out_ch.run_last = last_r;
  assign out_ch.is_empty = empty_r;
  assign out_ch.is_full  = full_r;

endmodule

/* tb/sv/block_ring_buffer_core_test.sv */
// Self-checking testbench for block_ring_buffer_core: message writes, chunked reads,
// ring-full drops, truncation and register changes, checked beat by beat.
// Depends on brb_pkg, brb_if and the block_ring_buffer_core RTL.
`timescale 1ns / 1ps

module block_ring_buffer_core_test;

  localparam int RING_MAX      = 16;
  localparam int BLOCK_CAP     = 256;
  localparam int READ_CHUNK    = 64;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 10;
  localparam int PHASE_BEATS   = 27;

  typedef struct {
    brb_pkg::kind_t kind;
    logic [7:0]     data;
    logic [8:0]     count;
    logic           last;
    logic           empty;
    logic           full;
  } ring_reply_t;

  // Tracks the message ring and the reply beats each request owes
  class msg_ring_model;
    bit [7:0]    blk_bytes [RING_MAX][BLOCK_CAP];
    int unsigned blk_len [RING_MAX];
    int unsigned blk_off [RING_MAX];
    int unsigned rd_blk, wr_blk, cursor;
    bit          dropping;
    bit [4:0]    blocks_reg;
    bit [8:0]    bytes_reg;
    ring_reply_t owed [$];
    int unsigned mismatches, checked;

    function new();
      foreach (blk_len[i]) begin
        blk_len[i] = 0;
        blk_off[i] = 0;
      end
      rd_blk = 0;
      wr_blk = 0;
      cursor = 0;
      dropping = 0;
      blocks_reg = brb_pkg::BLOCKS_RST;
      bytes_reg = brb_pkg::BYTES_RST;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned ring_n();
      if (blocks_reg < 2) return 2;
      if (blocks_reg > RING_MAX) return RING_MAX;
      return 32'(blocks_reg);
    endfunction

    function int unsigned cap_n();
      if (bytes_reg < 1) return 1;
      if (bytes_reg > BLOCK_CAP) return BLOCK_CAP;
      return 32'(bytes_reg);
    endfunction

    function int unsigned step_blk(int unsigned idx);
      return (idx + 1 >= ring_n()) ? 0 : idx + 1;
    endfunction

    function bit full_now();
      return step_blk(wr_blk) == rd_blk;
    endfunction

    function void write_reg(brb_pkg::cfg_reg_t idx, int unsigned v);
      if (idx == brb_pkg::REG_BLOCKS_IN_USE) blocks_reg = v[4:0];
      else bytes_reg = v[8:0];
    endfunction

    // Queue one reply beat; flags reflect the state after the update
    function void owe(brb_pkg::kind_t k, bit [7:0] d, int unsigned c, bit last);
      ring_reply_t r;
      r.kind = k;
      r.data = d;
      r.count = c[8:0];
      r.last = last;
      r.empty = (rd_blk == wr_blk);
      r.full = full_now();
      owed.push_back(r);
    endfunction

    function void note_beat(logic act, bit [7:0] d, bit fin, bit [6:0] rlen);
      int unsigned n, want, len, off, avail, size;
      bit [7:0] got [READ_CHUNK];
      n = ring_n();
      rd_blk = rd_blk % n;
      wr_blk = wr_blk % n;
      if (act == brb_pkg::ACT_WRITE) begin
        // Drop the whole message when it starts on a full ring
        if (cursor == 0 && !dropping && full_now()) dropping = 1;
        if (!dropping && cursor < cap_n()) begin
          blk_bytes[wr_blk][cursor] = d;
          cursor++;
        end
        if (!fin) return;
        len = 0;
        if (!dropping && !full_now()) begin
          len = cursor;
          blk_len[wr_blk] = cursor;
          blk_off[wr_blk] = 0;
          wr_blk = step_blk(wr_blk);
        end
        cursor = 0;
        dropping = 0;
        owe(brb_pkg::KIND_WRITE, 8'h00, len, 1'b1);
        return;
      end
      want = (rlen > READ_CHUNK) ? READ_CHUNK : rlen;
      if (rd_blk == wr_blk) begin
        owe(brb_pkg::KIND_NODATA, 8'h00, 0, 1'b1);
        return;
      end
      len = blk_len[rd_blk];
      off = blk_off[rd_blk];
      avail = (off < len) ? len - off : 0;
      size = (avail < want) ? avail : want;
      for (int k = 0; k < size; k++) got[k] = blk_bytes[rd_blk][off + k];
      // Advance past an exhausted block, else keep the offset
      off += size;
      if (off >= len) begin
        blk_off[rd_blk] = 0;
        rd_blk = step_blk(rd_blk);
      end else begin
        blk_off[rd_blk] = off;
      end
      if (size == 0) begin
        owe(brb_pkg::KIND_NODATA, 8'h00, 0, 1'b1);
        return;
      end
      for (int k = 0; k < size; k++) owe(brb_pkg::KIND_DATA, got[k], k + 1, k + 1 == size);
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [8:0] count,
                               logic last, logic empty, logic full);
      ring_reply_t e;
      checked++;
      if (owed.size() == 0) begin
        $display("%0t ns: reply beat with nothing expected, expected none, got kind %0d count %0d",
                 $time, kind, count);
        mismatches++;
        return;
      end
      e = owed.pop_front();
      compare_field("kind", 9'(e.kind), 9'(kind));
      compare_field("out_byte", 9'(e.data), 9'(data));
      compare_field("count", e.count, count);
      compare_field("run_last", 9'(e.last), 9'(last));
      compare_field("is_empty", 9'(e.empty), 9'(empty));
      compare_field("is_full", 9'(e.full), 9'(full));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  brb_pkg::cfg_reg_t cfg_index;
  logic [brb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  block_ring_buffer_core #(
    .MAX_BLOCKS    (RING_MAX),
    .BLOCK_CAPACITY(BLOCK_CAP),
    .MAX_READ_CHUNK(READ_CHUNK)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  msg_ring_model ring;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned beats_in = 0;
  int unsigned directed_beats = 0;
  int unsigned reg_writes = 0;
  bit calm_source = 0;
  bit calm_sink = 0;

  int unsigned phase_blocks [PHASES] = '{16, 2, 4, 0, 31, 7, 17, 1, 9, 16};
  int unsigned phase_bytes [PHASES] = '{256, 1, 16, 0, 511, 300, 5, 257, 64, 256};

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none at all when calm
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit [6:0] pick_read_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'($urandom_range(9, 64));
    if (r == 2) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(1, 8));
  endfunction

  // Stall the reply channel at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= pick_gap(calm_sink);
    end
  end

  // Check every accepted reply beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      ring.check_result(out_ch.kind, out_ch.out_byte, out_ch.count, out_ch.run_last,
                        out_ch.is_empty, out_ch.is_full);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one beat after a random gap; valid stays high on return
  task automatic send_beat(logic act, bit [7:0] d, bit fin, bit [6:0] rlen);
    int unsigned gap;
    gap = pick_gap(calm_source);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data_byte <= d;
    in_ch.message_end <= fin;
    in_ch.read_len <= rlen;
    do @(posedge clk); while (!in_ch.ready);
    ring.note_beat(act, d, fin, rlen);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic post_byte(bit [7:0] d, bit fin);
    send_beat(brb_pkg::ACT_WRITE, d, fin, 7'($urandom_range(0, 127)));
  endtask

  task automatic post_read(bit [6:0] rlen);
    send_beat(brb_pkg::ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              rlen);
  endtask

  // Write a message of random bytes, now and then with a read slipped in
  task automatic post_message(int unsigned len);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) < 8) post_read(pick_read_len());
      post_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Hold off input until every owed reply has arrived, then let the core go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (ring.owed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register, then deassert cfg_we before the next drive
  task automatic write_reg(brb_pkg::cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[brb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    ring.write_reg(idx, v);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned start, cap, len, r;
    ring = new();
    in_ch.valid = 1'b0;
    in_ch.action = brb_pkg::ACT_WRITE;
    in_ch.data_byte = '0;
    in_ch.message_end = 1'b0;
    in_ch.read_len = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = brb_pkg::REG_BLOCKS_IN_USE;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reads on an empty ring, with and without a length
    post_read(7'd5);
    post_read(7'd0);
    // Three messages, extreme byte values
    post_byte(8'h00, 1'b1);
    post_byte(8'hFF, 1'b0);
    post_byte(8'hA5, 1'b0);
    post_byte(8'h5A, 1'b1);
    post_byte(8'h81, 1'b1);
    // Shrink the ring under an open message so its commit finds the ring full
    post_byte(8'h3C, 1'b0);
    settle();
    write_reg(brb_pkg::REG_BLOCKS_IN_USE, 2);
    post_byte(8'hC3, 1'b1);
    // Message starting on a full ring is dropped whole
    post_byte(8'h7E, 1'b0);
    post_byte(8'hE7, 1'b1);
    // Zero length moves nothing; an oversized length saturates
    post_read(7'd0);
    post_read(7'd127);
    // Truncate a message to a two-byte block
    settle();
    write_reg(brb_pkg::REG_BLOCK_BYTES, 2);
    post_byte(8'h01, 1'b0);
    post_byte(8'h02, 1'b0);
    post_byte(8'h04, 1'b0);
    post_byte(8'h08, 1'b1);
    // Grow the ring so read index sweeps blocks that never held a message
    settle();
    write_reg(brb_pkg::REG_BLOCKS_IN_USE, 16);
    post_read(7'd1);
    post_read(7'd64);
    post_read(7'd64);
    post_read(7'd7);
    directed_beats = beats_in;

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(brb_pkg::REG_BLOCKS_IN_USE, phase_blocks[p]);
      write_reg(brb_pkg::REG_BLOCK_BYTES, phase_bytes[p]);
      calm_source = (p % 3 == 1);
      calm_sink = (p % 4 == 2);
      cap = ring.cap_n();
      start = beats_in;
      while (beats_in - start < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          settle();
        end else if (r < 53) begin
          if ($urandom_range(0, 15) == 0) len = $urandom_range(1, (cap <= 64) ? cap + 3 : 70);
          else len = $urandom_range(1, 6);
          post_message(len);
        end else begin
          post_read(pick_read_len());
        end
      end
    end

    settle();
    $display("Sent %0d input beats (%0d directed) over %0d register writes;",
             beats_in, directed_beats, reg_writes);
    $display("checked %0d reply beats with %0d mismatches.", ring.checked, ring.mismatches);
    if (ring.mismatches == 0 && ring.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/brb_pkg.sv
rtl/core/brb_if.sv
rtl/core/brb_data_mem.sv
rtl/core/brb_meta_mem.sv
rtl/core/brb_index.sv
rtl/core/block_ring_buffer_core.sv
tb/sv/block_ring_buffer_core_test.sv
